// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the IIR filter core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define AST_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/iirdf_pkg.sv =====
// Shared types, constants and helpers for the direct form I IIR filter core.
// No dependencies.
package iirdf_pkg;

  localparam int MAX_ORDER  = 3;
  localparam int COEF_TAPS  = 3;
  localparam int TAPS       = (MAX_ORDER < COEF_TAPS) ? MAX_ORDER : COEF_TAPS;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int FRAC_BITS  = 14;
  localparam int ORDER_W    = 2;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  // 2*TAPS+1 products of at most 2^(PROD_W-1) each, plus sign headroom
  localparam int ACC_W      = PROD_W + 3;
  localparam int RES_W      = ACC_W - FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QLVL_W  = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FF3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB3   = 3'd7;

  localparam logic [ORDER_W-1:0]       ORDER_RST = 2'd3;
  localparam logic signed [COEF_W-1:0] UNITY     = 18'sd16384;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    coef_t [COEF_TAPS:0] ff;   // ff[k]: tap k
    coef_t [COEF_TAPS:1] fb;   // fb[k]: tap k
  } cfg_t;

  typedef struct packed {
    logic vld;
    acc_t ff_sum;
  } ff_item_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } q_stat_t;

  function automatic prod_t mul(coef_t c, sample_t s);
    prod_t ce;
    prod_t se;
    ce = PROD_W'(c);
    se = PROD_W'(s);
    return ce * se;
  endfunction

endpackage

// ===== rtl/core/iir_direct_form_filter_core.sv =====
// Direct form I IIR filter, order up to three, Q3.14 coefficients. Takes one
// signed 16-bit sample per transaction and returns one rounded, saturated sample
// with a clip flag in tuser. Sustains one sample per clock while m_tready stays high;
// each sample passes the product registers, the queue and the output register. The
// rate is set by the feedback path: the three feedback products of past outputs, the
// accumulate, rounding and saturation are combinational in the back end, while the
// feedforward sum is formed ahead of it in the front end. Coefficients and order must
// be written through the cfg port while the stream is idle; the block does not enforce it.
// Depends on iirdf_pkg, iirdf_front, iirdf_queue, iirdf_back, assert_macros.svh.
`include "assert_macros.svh"

module iir_direct_form_filter_core import iirdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] sample_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] sample_out
  output logic                  m_tuser    // [0] clipped
);

  cfg_t     cfg;
  ff_item_t push;
  ff_item_t head;
  q_stat_t  qstat;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order             <= ORDER_RST;
      cfg.ff[COEF_TAPS:1]   <= '0;
      cfg.fb                <= '0;
      cfg.ff[0]             <= UNITY;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORDER: cfg.order <= cfg_wdata[ORDER_W-1:0];
        REG_FF0:   cfg.ff[0] <= cfg_wdata;
        REG_FF1:   cfg.ff[1] <= cfg_wdata;
        REG_FF2:   cfg.ff[2] <= cfg_wdata;
        REG_FF3:   cfg.ff[3] <= cfg_wdata;
        REG_FB1:   cfg.fb[1] <= cfg_wdata;
        REG_FB2:   cfg.fb[2] <= cfg_wdata;
        REG_FB3:   cfg.fb[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  iirdf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat    (qstat),
    .push     (push)
  );

  iirdf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  iirdf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // credit check in the front must keep the queue from overflowing
  `AST_IMP(a_no_overflow, clk, rst, push.vld, qstat.level < QLVL_W'(QDEPTH))
  `AST_IMP(a_no_underflow, clk, rst, pop, qstat.level != '0)
  // every accepted sample is presented as a queue push in the cycle after it is accepted
  `AST_NEXT(a_accept_to_queue, clk, rst, s_tvalid && s_tready, push.vld)

endmodule

// ===== rtl/core/iirdf_front.sv =====
// Front end: accepts samples, keeps the input delay line and forms the feedforward sum.
// Depends on iirdf_pkg; feeds iirdf_queue.
module iirdf_front import iirdf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // [15:0] sample_in
  input  q_stat_t        qstat,
  output ff_item_t       push
);

  sample_t           past_in [MAX_ORDER];
  prod_t             prod    [TAPS+1];
  logic              p_vld;
  logic              accept;
  logic [QLVL_W-1:0] committed;
  sample_t           x;
  acc_t              sum;

  assign x         = s_tdata;
  // queue slots already taken plus the one in the product stage
  assign committed = qstat.level + QLVL_W'(p_vld);
  assign s_tready  = committed < QLVL_W'(QDEPTH);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) past_in[i] <= '0;
    end else begin
      p_vld <= accept;
      if (accept) begin
        past_in[0] <= x;
        for (int i = 1; i < MAX_ORDER; i++) past_in[i] <= past_in[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod[0] <= mul(cfg.ff[0], x);
      for (int k = 1; k <= TAPS; k++)
        prod[k] <= (int'(cfg.order) >= k) ? mul(cfg.ff[k], past_in[k-1]) : '0;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k <= TAPS; k++) sum = sum + ACC_W'(prod[k]);
  end

  assign push.vld    = p_vld;
  assign push.ff_sum = sum;

endmodule

// ===== rtl/core/iirdf_queue.sv =====
// Short queue of feedforward sums between the front and back ends.
// Depends on iirdf_pkg.
module iirdf_queue import iirdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ff_item_t push,
  input  logic     pop,
  output ff_item_t head,
  output q_stat_t  qstat
);

  acc_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.vld) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)      rd_ptr <= rd_ptr + QPTR_W'(1);
      level <= level + QLVL_W'(push.vld) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) entries[wr_ptr] <= push.ff_sum;
  end

  assign head.vld    = level != '0;
  assign head.ff_sum = entries[rd_ptr];
  assign qstat.level = level;

endmodule

// ===== rtl/core/iirdf_back.sv =====
// Back end: feedback multiply-accumulate, rounding, saturation and the output register.
// Depends on iirdf_pkg; drains iirdf_queue.
module iirdf_back import iirdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  ff_item_t    head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  output logic        m_tuser    // [0] clipped
);

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

  sample_t                 past_out [MAX_ORDER];
  acc_t                    acc;
  acc_t                    rnd;
  logic signed [RES_W-1:0] yw;
  sample_t                 y;
  logic                    clip;

  assign pop = head.vld && (!m_tvalid || m_tready);

  always_comb begin
    acc = head.ff_sum;
    for (int k = 1; k <= TAPS; k++)
      if (int'(cfg.order) >= k) acc = acc - ACC_W'(mul(cfg.fb[k], past_out[k-1]));
    rnd = acc + ACC_W'(1 << (FRAC_BITS - 1));
    yw  = RES_W'(rnd >>> FRAC_BITS);
    if (yw > SAT_HI) begin
      y    = 16'sh7fff;
      clip = 1'b1;
    end else if (yw < SAT_LO) begin
      y    = -16'sh8000;
      clip = 1'b1;
    end else begin
      y    = SAMPLE_W'(yw);
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) past_out[i] <= '0;
    end else begin
      if (pop) begin
        m_tvalid    <= 1'b1;
        past_out[0] <= y;
        for (int i = 1; i < MAX_ORDER; i++) past_out[i] <= past_out[i-1];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= y;
      m_tuser <= clip;
    end
  end

endmodule
